FILE: rtl/cgp_pkg.sv
// shared types and constants for the combining glyph placer
// item and result payload structs, placement class codes, placement offsets
// no dependencies
`default_nettype none

package cgp_pkg;

   // one input item: character code plus its looked-up glyph record
   typedef struct packed {
      logic       run_start;
      logic [7:0] char_code;
      logic [7:0] glyph_width;
      logic [7:0] glyph_top;
      logic [7:0] glyph_bottom;
      logic [7:0] glue_width;
      logic [7:0] advance_width;
      logic [3:0] glyph_class;
   } req_type;

   // one result item
   typedef struct packed {
      logic               draw;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        run_width;
   } rsp_type;

   // placement classes
   localparam logic [3:0] CLS_NORMAL     = 4'd0;
   localparam logic [3:0] CLS_GLUE       = 4'd1;
   localparam logic [3:0] CLS_LEFT       = 4'd2;
   localparam logic [3:0] CLS_RIGHT      = 4'd3;
   localparam logic [3:0] CLS_FIRST_A    = 4'd4;
   localparam logic [3:0] CLS_FIRST_B    = 4'd5;
   localparam logic [3:0] CLS_TOP_LEFT   = 4'd6;
   localparam logic [3:0] CLS_TOP_CENTER = 4'd7;
   localparam logic [3:0] CLS_TOP_RIGHT  = 4'd8;
   localparam logic [3:0] CLS_TOP_DOT    = 4'd9;
   localparam logic [3:0] CLS_BOT_LEFT   = 4'd10;
   localparam logic [3:0] CLS_BOT_CENTER = 4'd11;
   localparam logic [3:0] CLS_BOT_RIGHT  = 4'd12;
   localparam logic [3:0] CLS_BOT_DOT    = 4'd13;
   localparam logic [3:0] CLS_BOT_EXTRA  = 4'd14;
   localparam logic [3:0] CLS_RESTORE    = 4'd15;

   // highest control code, which gives no result
   localparam logic [7:0] CTRL_CODE_MAX = 8'd31;

   // mark offsets in pixels
   localparam logic [3:0] TOP_RIGHT_INSET = 4'd3;
   localparam logic [3:0] DOT_INSET       = 4'd2;
   localparam logic [3:0] BOT_DOT_DROP    = 4'd1;

endpackage

`default_nettype wire

FILE: rtl/cgp_core.sv
// placement state and the single-pass placement logic for one item
// uses cgp_pkg for payload types, class codes and offsets
`default_nettype none

module cgp_core #(
   parameter int COORD_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire cgp_pkg::req_type item,
   input  wire logic [7:0]      char_gap,
   output logic                 res_valid,
   output cgp_pkg::rsp_type     res
);

   localparam int CB = COORD_BITS;

   // signed halving, truncating toward zero
   function automatic logic [CB-1:0] halve(input logic [CB-1:0] v);
      logic [CB-1:0] adj;
      adj = v + CB'(v[CB-1]);
      return CB'($signed(adj) >>> 1);
   endfunction

   // pen position; marks leave it unchanged, and no separate saved pen is kept
   logic [CB-1:0] pen_ff, pen_in;
   logic [CB-1:0] base_left_ff, base_left_in;
   logic [CB-1:0] base_right_ff, base_right_in;
   logic [7:0]    base_top_ff, base_top_in;
   logic [7:0]    base_bottom_ff, base_bottom_in;
   logic          have_base_ff, have_base_in;
   logic [CB-1:0] width_sum_ff, width_sum_in;

   logic [CB-1:0] pen_cur, left_cur, right_cur, sum_cur;
   logic [7:0]    top_cur, bottom_cur;
   logic          have_cur;

   logic [CB-1:0] w, g, a, gap, rise, over, span, centre, right_w;
   logic [CB-1:0] pen_adj, mark_x, mark_y;
   logic          is_char, is_base, is_mark, draw;

   // run start clears the state in front of this item
   assign pen_cur    = item.run_start ? '0 : pen_ff;
   assign left_cur   = item.run_start ? '0 : base_left_ff;
   assign right_cur  = item.run_start ? '0 : base_right_ff;
   assign top_cur    = item.run_start ? '0 : base_top_ff;
   assign bottom_cur = item.run_start ? '0 : base_bottom_ff;
   assign have_cur   = item.run_start ? 1'b0 : have_base_ff;
   assign sum_cur    = item.run_start ? '0 : width_sum_ff;

   assign w   = CB'(item.glyph_width);
   assign g   = CB'(item.glue_width);
   assign a   = CB'(item.advance_width);
   assign gap = CB'(char_gap);

   assign rise    = CB'(item.glyph_bottom) - CB'(item.glyph_top);
   assign over    = CB'(top_cur) - rise;
   assign span    = right_cur - left_cur - w;
   assign centre  = left_cur + halve(span);
   assign right_w = right_cur - w;

   assign is_char = item.char_code > cgp_pkg::CTRL_CODE_MAX;
   assign is_base = item.glyph_class <= cgp_pkg::CLS_FIRST_B;
   assign is_mark = !is_base && (item.glyph_class != cgp_pkg::CLS_RESTORE);
   assign draw    = is_base || (is_mark && have_cur);

   always_comb begin
      case (item.glyph_class) inside
         cgp_pkg::CLS_RIGHT:                        pen_adj = pen_cur + g - w;
         cgp_pkg::CLS_FIRST_A, cgp_pkg::CLS_FIRST_B: pen_adj = pen_cur + g - a;
         default:                                   pen_adj = pen_cur;
      endcase
   end

   always_comb begin
      mark_x = left_cur;
      mark_y = CB'(bottom_cur);
      case (item.glyph_class)
         cgp_pkg::CLS_TOP_LEFT: begin
            mark_x = left_cur;
            mark_y = over;
         end
         cgp_pkg::CLS_TOP_CENTER: begin
            mark_x = centre;
            mark_y = over;
         end
         cgp_pkg::CLS_TOP_RIGHT: begin
            mark_x = right_w - CB'(cgp_pkg::TOP_RIGHT_INSET);
            mark_y = over;
         end
         cgp_pkg::CLS_TOP_DOT: begin
            mark_x = right_w - CB'(cgp_pkg::DOT_INSET);
            mark_y = halve(over);
         end
         cgp_pkg::CLS_BOT_LEFT: begin
            mark_x = left_cur;
         end
         cgp_pkg::CLS_BOT_CENTER: begin
            mark_x = centre;
         end
         cgp_pkg::CLS_BOT_RIGHT: begin
            mark_x = right_w;
         end
         cgp_pkg::CLS_BOT_DOT: begin
            mark_x = right_w - CB'(cgp_pkg::DOT_INSET);
            mark_y = CB'(bottom_cur) + CB'(cgp_pkg::BOT_DOT_DROP);
         end
         cgp_pkg::CLS_BOT_EXTRA: begin
            mark_x = right_w - CB'(cgp_pkg::DOT_INSET);
            mark_y = CB'(bottom_cur) - rise;
         end
         default: begin
            mark_x = left_cur;
            mark_y = CB'(bottom_cur);
         end
      endcase
   end

   // state after this item
   always_comb begin
      pen_in         = pen_cur;
      base_left_in   = left_cur;
      base_right_in  = right_cur;
      base_top_in    = top_cur;
      base_bottom_in = bottom_cur;
      have_base_in   = have_cur;
      width_sum_in   = sum_cur;
      if (is_char) begin
         if (is_base && (item.glyph_class != cgp_pkg::CLS_NORMAL)) begin
            base_top_in    = item.glyph_top;
            base_bottom_in = item.glyph_bottom;
            have_base_in   = 1'b1;
            pen_in         = pen_cur + g;
         end
         case (item.glyph_class) inside
            cgp_pkg::CLS_NORMAL: begin
               have_base_in = 1'b0;
               pen_in       = pen_cur + w + gap;
               width_sum_in = sum_cur + w + gap;
            end
            cgp_pkg::CLS_GLUE: begin
               base_left_in  = pen_cur;
               base_right_in = pen_cur + w;
               width_sum_in  = sum_cur + g;
            end
            cgp_pkg::CLS_LEFT, cgp_pkg::CLS_RIGHT: begin
               base_left_in  = pen_cur;
               base_right_in = pen_cur + g;
               width_sum_in  = sum_cur + g;
            end
            cgp_pkg::CLS_FIRST_A, cgp_pkg::CLS_FIRST_B: begin
               base_left_in  = pen_adj;
               base_right_in = pen_adj + w;
               width_sum_in  = sum_cur + a;
            end
            default: begin
               pen_in = pen_cur;
            end
         endcase
      end
   end

   always_comb begin
      res_valid     = is_char;
      res.draw      = draw;
      res.pos_x     = draw ? 16'(is_base ? pen_adj : mark_x) : '0;
      res.pos_y     = (draw && is_mark) ? 16'(mark_y) : '0;
      res.run_width = 16'(width_sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff         <= '0;
         base_left_ff   <= '0;
         base_right_ff  <= '0;
         base_top_ff    <= '0;
         base_bottom_ff <= '0;
         have_base_ff   <= 1'b0;
         width_sum_ff   <= '0;
      end else if (fire) begin
         pen_ff         <= pen_in;
         base_left_ff   <= base_left_in;
         base_right_ff  <= base_right_in;
         base_top_ff    <= base_top_in;
         base_bottom_ff <= base_bottom_in;
         have_base_ff   <= have_base_in;
         width_sum_ff   <= width_sum_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/combining_glyph_placer_unit.sv
// combining glyph placer: an accepted item waits in the input register; its result is written
// to the result register when the result register is empty or drains, and shows on rsp_valid
// throughput one item per cycle; the input stalls only while a result waits under rsp_stall
// reset (synchronous) empties both registers, clears all placement state and
// sets char_gap to zero
// top level; uses cgp_pkg and cgp_core
`default_nettype none

module combining_glyph_placer_unit #(
   parameter int COORD_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   // item channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cgp_pkg::req_type req_item,
   // result channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cgp_pkg::rsp_type      rsp_item
);

   // extra pixels after each lone normal glyph
   logic [7:0] char_gap_ff;

   // input register
   logic             in_valid_ff, in_valid_in;
   cgp_pkg::req_type in_item_ff;

   // result register
   logic             out_valid_ff, out_valid_in;
   cgp_pkg::rsp_type out_item_ff;

   logic             in_take;   // transfer on the item channel
   logic             advance;   // input register item processed this cycle
   logic             out_taken; // transfer on the result channel
   logic             res_valid;
   cgp_pkg::rsp_type res;

   // the input register moves on when the result register is empty or drains
   assign out_taken = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   // placement state and logic; control codes give no result and change state only at a run start
   cgp_core #(
      .COORD_BITS(COORD_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_item_ff),
      .char_gap (char_gap_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         char_gap_ff  <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            char_gap_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

FILE: rtl/cgp_checker.sv
// port-level checks for the combining glyph placer, bound to the top level
// uses cgp_pkg for the payload types
`default_nettype none

module cgp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire cgp_pkg::rsp_type rsp_item
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset empties the input register
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // a glyph not drawn carries a zero position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.draw |-> (rsp_item.pos_x == 16'sd0) && (rsp_item.pos_y == 16'sd0))
      else $error("undrawn glyph with position");

endmodule

bind combining_glyph_placer_unit cgp_checker u_cgp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_item (rsp_item)
);

`default_nettype wire

FILE: bench/combining_glyph_placer_unit_tb.sv
// self-checking bench for combining_glyph_placer_unit: directed glyph table, then random clusters
// every accepted result is checked against an in-bench placement predictor or a typed row's result
// depends on cgp_pkg and combining_glyph_placer_unit
`timescale 1ns / 1ps

module combining_glyph_placer_unit_tb;

   // run limit in cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   // cycles to let the block drain after the last result
   localparam int DRAIN_CYCLES = 4;

   // one row of the directed table; typed rows carry a hand-written result
   typedef struct {
      cgp_pkg::req_type item;
      bit               typed;
      bit               typed_has;
      cgp_pkg::rsp_type typed_rsp;
   } glyph_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [7:0]       csr_wr_data = 8'd0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cgp_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cgp_pkg::rsp_type rsp_item;

   // predictor state, mirrors the block's placement registers plus a saved pen the block does not keep
   logic [15:0] pen, saved_pen, box_left, box_right, run_sum;
   logic [7:0]  box_top, box_bot;
   bit          base_ok;
   logic [7:0]  gap_reg;

   cgp_pkg::rsp_type pending_placements[$];
   glyph_row_type    glyph_table[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               glyphs_sent = 0;
   int               send_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               rsp_hold_left = 0;
   bit               quiet = 1'b0;

   combining_glyph_placer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   always #1 clock = ~clock;

   // one line per failure; printing is capped so a broken block cannot flood the log
   task automatic flag_error(input string msg);
      if (error_count < 200) $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_placement();
      pen = '0;
      saved_pen = '0;
      box_left = '0;
      box_right = '0;
      box_top = '0;
      box_bot = '0;
      base_ok = 1'b0;
      run_sum = '0;
   endfunction

   // works out the result of one glyph and advances the predictor state;
   // returns 0 for a control code, which gives no result
   function automatic bit place_glyph(input cgp_pkg::req_type it,
                                      output cgp_pkg::rsp_type r);
      logic [15:0]        wd, g, a, yv, centre;
      logic [15:0]        step, sum_add;
      logic signed [15:0] span;
      logic [3:0]         cls;
      int                 rise, over, top_i, bot_i;
      bit                 draw_it;
      r = '0;
      if (it.run_start) clear_placement();
      if (it.char_code <= cgp_pkg::CTRL_CODE_MAX) return 1'b0;
      wd = {8'd0, it.glyph_width};
      g = {8'd0, it.glue_width};
      a = {8'd0, it.advance_width};
      cls = it.glyph_class;
      top_i = int'(box_top);
      bot_i = int'(box_bot);
      rise = int'({1'b0, it.glyph_bottom}) - int'({1'b0, it.glyph_top});
      draw_it = 1'b1;
      yv = '0;

      // placement, against the box as it stood before this glyph
      case (cls)
         cgp_pkg::CLS_RIGHT: pen = pen + g - wd;
         cgp_pkg::CLS_FIRST_A, cgp_pkg::CLS_FIRST_B: pen = pen + g - a;
         cgp_pkg::CLS_RESTORE: draw_it = 1'b0;
         cgp_pkg::CLS_NORMAL, cgp_pkg::CLS_GLUE, cgp_pkg::CLS_LEFT: ;
         default: begin
            if (!base_ok) begin
               draw_it = 1'b0;
            end else begin
               span = box_right - box_left - wd;
               centre = box_left + 16'(int'(span) / 2);
               over = top_i - rise;
               case (cls)
                  cgp_pkg::CLS_TOP_LEFT: begin
                     yv = 16'(over);
                     pen = box_left;
                  end
                  cgp_pkg::CLS_TOP_CENTER: begin
                     yv = 16'(over);
                     pen = centre;
                  end
                  cgp_pkg::CLS_TOP_RIGHT: begin
                     yv = 16'(over);
                     pen = box_right - wd - 16'(cgp_pkg::TOP_RIGHT_INSET);
                  end
                  cgp_pkg::CLS_TOP_DOT: begin
                     yv = 16'(over / 2);
                     pen = box_right - wd - 16'(cgp_pkg::DOT_INSET);
                  end
                  cgp_pkg::CLS_BOT_LEFT: begin
                     yv = 16'(box_bot);
                     pen = box_left;
                  end
                  cgp_pkg::CLS_BOT_CENTER: begin
                     yv = 16'(box_bot);
                     pen = centre;
                  end
                  cgp_pkg::CLS_BOT_RIGHT: begin
                     yv = 16'(box_bot);
                     pen = box_right - wd;
                  end
                  cgp_pkg::CLS_BOT_DOT: begin
                     yv = 16'(box_bot) + 16'(cgp_pkg::BOT_DOT_DROP);
                     pen = box_right - wd - 16'(cgp_pkg::DOT_INSET);
                  end
                  default: begin
                     yv = 16'(bot_i - rise);
                     pen = box_right - wd - 16'(cgp_pkg::DOT_INSET);
                  end
               endcase
            end
         end
      endcase

      r.draw = draw_it;
      r.pos_x = draw_it ? pen : '0;
      r.pos_y = draw_it ? yv : '0;

      // state update after placement
      if (cls == cgp_pkg::CLS_NORMAL) begin
         base_ok = 1'b0;
         pen = pen + wd + 16'(gap_reg);
         run_sum = run_sum + wd + 16'(gap_reg);
         saved_pen = pen;
      end else if (cls <= cgp_pkg::CLS_FIRST_B) begin
         step = g;
         sum_add = g;
         box_left = pen;
         box_right = pen + wd;
         if (cls == cgp_pkg::CLS_LEFT) begin
            box_right = pen + g;
         end else if (cls == cgp_pkg::CLS_RIGHT) begin
            box_left = pen + wd - g;
            step = wd;
         end else if (cls >= cgp_pkg::CLS_FIRST_A) begin
            step = a;
            sum_add = a;
         end
         box_top = it.glyph_top;
         box_bot = it.glyph_bottom;
         base_ok = 1'b1;
         pen = pen + step;
         run_sum = run_sum + sum_add;
         saved_pen = pen;
      end else begin
         pen = saved_pen;
      end
      r.run_width = run_sum;
      return 1'b1;
   endfunction

   function automatic cgp_pkg::req_type glyph(input int rs, input int code, input int w,
                                              input int t, input int b, input int g,
                                              input int a, input logic [3:0] cls);
      cgp_pkg::req_type it;
      it.run_start = 1'(rs);
      it.char_code = 8'(code);
      it.glyph_width = 8'(w);
      it.glyph_top = 8'(t);
      it.glyph_bottom = 8'(b);
      it.glue_width = 8'(g);
      it.advance_width = 8'(a);
      it.glyph_class = cls;
      return it;
   endfunction

   // row with a hand-written result
   function automatic glyph_row_type fixed_row(input cgp_pkg::req_type it, input int has,
                                               input int dr, input int x, input int y,
                                               input int rw);
      glyph_row_type row;
      row.item = it;
      row.typed = 1'b1;
      row.typed_has = 1'(has);
      row.typed_rsp.draw = 1'(dr);
      row.typed_rsp.pos_x = 16'(x);
      row.typed_rsp.pos_y = 16'(y);
      row.typed_rsp.run_width = 16'(rw);
      return row;
   endfunction

   // row left to the predictor
   function automatic glyph_row_type pred_row(input cgp_pkg::req_type it);
      glyph_row_type row;
      row.item = it;
      row.typed = 1'b0;
      row.typed_has = 1'b0;
      row.typed_rsp = '0;
      return row;
   endfunction

   function automatic cgp_pkg::req_type rand_glyph(input logic [3:0] cls);
      cgp_pkg::req_type it;
      it.run_start = ($urandom_range(0, 31) == 0);
      it.char_code = 8'($urandom_range(int'(cgp_pkg::CTRL_CODE_MAX) + 1, 255));
      it.glyph_width = 8'($urandom);
      it.glyph_top = 8'($urandom);
      it.glyph_bottom = 8'($urandom);
      it.glue_width = 8'($urandom);
      it.advance_width = 8'($urandom);
      it.glyph_class = cls;
      return it;
   endfunction

   // drives one transfer, holds it until accepted, then maybe idles for a burst;
   // a typed row overrides the predicted result but still advances the predictor
   task automatic send_glyph(input cgp_pkg::req_type it, input bit typed = 1'b0,
                             input bit typed_has = 1'b0,
                             input cgp_pkg::rsp_type typed_rsp = '0);
      cgp_pkg::rsp_type want;
      bit               has;
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      has = place_glyph(it, want);
      if (typed) begin
         has = typed_has;
         want = typed_rsp;
      end
      if (has) pending_placements.push_back(want);
      if (it.char_code > cgp_pkg::CTRL_CODE_MAX) glyphs_sent++;
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // char_gap may only change with the block idle: wait out every result,
   // then let any control code that may still be in flight drain
   task automatic write_gap(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      gap_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   // random glyph stream, mostly base-plus-marks clusters with random content
   task automatic run_phase(input int target);
      int               start_cnt;
      int               pick;
      cgp_pkg::req_type it;
      start_cnt = glyphs_sent;
      while (glyphs_sent - start_cnt < target) begin
         if ($urandom_range(0, 15) == 0) send_idle_pct = pick_idle_pct();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // well-formed cluster: a base, up to three marks, sometimes a restore
            send_glyph(rand_glyph(4'($urandom_range(cgp_pkg::CLS_GLUE,
                                                    cgp_pkg::CLS_FIRST_B))));
            repeat ($urandom_range(0, 3))
               send_glyph(rand_glyph(4'($urandom_range(cgp_pkg::CLS_TOP_LEFT,
                                                       cgp_pkg::CLS_BOT_EXTRA))));
            if ($urandom_range(0, 4) == 0) send_glyph(rand_glyph(cgp_pkg::CLS_RESTORE));
         end else if (pick < 72) begin
            // lone normal glyph, sometimes followed by an orphan mark
            send_glyph(rand_glyph(cgp_pkg::CLS_NORMAL));
            if ($urandom_range(0, 2) == 0)
               send_glyph(rand_glyph(4'($urandom_range(cgp_pkg::CLS_TOP_LEFT,
                                                       cgp_pkg::CLS_BOT_EXTRA))));
         end else if (pick < 85) begin
            send_glyph(rand_glyph(4'($urandom_range(cgp_pkg::CLS_NORMAL,
                                                    cgp_pkg::CLS_RESTORE))));
         end else if (pick < 93) begin
            // control code, with or without a run start
            it = rand_glyph(4'($urandom_range(cgp_pkg::CLS_NORMAL, cgp_pkg::CLS_RESTORE)));
            it.char_code = 8'($urandom_range(0, int'(cgp_pkg::CTRL_CODE_MAX)));
            it.run_start = 1'($urandom_range(0, 1));
            send_glyph(it);
         end else begin
            it = rand_glyph(4'($urandom_range(cgp_pkg::CLS_NORMAL, cgp_pkg::CLS_RESTORE)));
            it.run_start = 1'b1;
            send_glyph(it);
         end
      end
   endtask

   // result side: random stall bursts, at a stall rate that is re-chosen at random
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) rsp_idle_pct = pick_idle_pct();
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker: each accepted transfer against the oldest expectation
   always @(posedge clock) begin : check_results
      cgp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_placements.size() == 0) begin
            flag_error($sformatf("result with nothing expected: draw=%0b x=%0d y=%0d w=%0d",
                                 rsp_item.draw, rsp_item.pos_x, rsp_item.pos_y,
                                 rsp_item.run_width));
         end else begin
            want = pending_placements.pop_front();
            if (rsp_item.draw !== want.draw || rsp_item.pos_x !== want.pos_x ||
                rsp_item.pos_y !== want.pos_y || rsp_item.run_width !== want.run_width)
               flag_error($sformatf({"got draw=%0b x=%0d y=%0d w=%0d, ",
                                     "want draw=%0b x=%0d y=%0d w=%0d"},
                                    rsp_item.draw, rsp_item.pos_x, rsp_item.pos_y,
                                    rsp_item.run_width, want.draw, want.pos_x,
                                    want.pos_y, want.run_width));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      gap_reg = 8'd0;
      clear_placement();

      // directed glyphs: control codes, orphan marks, every class, field extremes
      glyph_table.push_back(fixed_row(glyph(1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                            cgp_pkg::CLS_RESTORE), 0, 0, 0, 0, 0));
      glyph_table.push_back(fixed_row(glyph(0, int'(cgp_pkg::CTRL_CODE_MAX), 8'hFF,
                                            0, 0, 0, 0, cgp_pkg::CLS_NORMAL),
                                      0, 0, 0, 0, 0));
      // mark right after reset has no base
      glyph_table.push_back(fixed_row(glyph(0, 8'h20, 5, 1, 4, 2, 3, cgp_pkg::CLS_TOP_LEFT),
                                      1, 0, 0, 0, 0));
      glyph_table.push_back(fixed_row(glyph(0, 8'hFF, 9, 9, 9, 9, 9, cgp_pkg::CLS_RESTORE),
                                      1, 0, 0, 0, 0));
      // widest normal glyph, then a zero-width one
      glyph_table.push_back(fixed_row(glyph(0, 8'h41, 8'hFF, 0, 0, 0, 0,
                                            cgp_pkg::CLS_NORMAL), 1, 1, 0, 0, 255));
      glyph_table.push_back(fixed_row(glyph(0, 8'h42, 0, 0, 0, 0, 0, cgp_pkg::CLS_NORMAL),
                                      1, 1, 255, 0, 255));
      // a normal glyph drops the base, so this mark is an orphan too
      glyph_table.push_back(fixed_row(glyph(0, 8'h80, 4, 2, 6, 1, 1,
                                            cgp_pkg::CLS_BOT_EXTRA), 1, 0, 0, 0, 255));
      glyph_table.push_back(pred_row(glyph(0, 8'h81, 12, 3, 14, 9, 0, cgp_pkg::CLS_GLUE)));
      glyph_table.push_back(pred_row(glyph(0, 8'h90, 4, 0, 2, 0, 0,
                                           cgp_pkg::CLS_TOP_LEFT)));
      glyph_table.push_back(pred_row(glyph(0, 8'h91, 5, 1, 3, 0, 0,
                                           cgp_pkg::CLS_TOP_CENTER)));
      glyph_table.push_back(pred_row(glyph(0, 8'h92, 8'hFF, 0, 0, 0, 0,
                                           cgp_pkg::CLS_TOP_RIGHT)));
      // tall dot: the raise goes negative and is halved toward zero
      glyph_table.push_back(pred_row(glyph(0, 8'h93, 2, 0, 8'hFF, 0, 0,
                                           cgp_pkg::CLS_TOP_DOT)));
      glyph_table.push_back(pred_row(glyph(0, 8'h94, 3, 1, 2, 0, 0,
                                           cgp_pkg::CLS_BOT_LEFT)));
      glyph_table.push_back(pred_row(glyph(0, 8'h95, 8'hFF, 0, 1, 0, 0,
                                           cgp_pkg::CLS_BOT_CENTER)));
      glyph_table.push_back(pred_row(glyph(0, 8'h96, 6, 2, 5, 0, 0,
                                           cgp_pkg::CLS_BOT_RIGHT)));
      glyph_table.push_back(pred_row(glyph(0, 8'h97, 1, 0, 0, 0, 0,
                                           cgp_pkg::CLS_BOT_DOT)));
      glyph_table.push_back(pred_row(glyph(0, 8'h98, 7, 8'hFF, 0, 0, 0,
                                           cgp_pkg::CLS_BOT_EXTRA)));
      glyph_table.push_back(pred_row(glyph(0, 8'hA0, 7, 10, 20, 20, 0, cgp_pkg::CLS_LEFT)));
      glyph_table.push_back(pred_row(glyph(0, 8'hA1, 3, 0, 4, 0, 0,
                                           cgp_pkg::CLS_BOT_CENTER)));
      // right-joining glyph with the pen stepping backward
      glyph_table.push_back(pred_row(glyph(0, 8'hB0, 8'hFF, 4, 9, 0, 0,
                                           cgp_pkg::CLS_RIGHT)));
      glyph_table.push_back(pred_row(glyph(0, 8'hB1, 1, 2, 3, 0, 0,
                                           cgp_pkg::CLS_TOP_CENTER)));
      glyph_table.push_back(pred_row(glyph(0, 8'hC0, 30, 5, 25, 0, 8'hFF,
                                           cgp_pkg::CLS_FIRST_A)));
      glyph_table.push_back(pred_row(glyph(0, 8'hC1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0,
                                           cgp_pkg::CLS_FIRST_B)));
      glyph_table.push_back(pred_row(glyph(0, 8'hC2, 9, 3, 7, 0, 0,
                                           cgp_pkg::CLS_TOP_DOT)));
      // new run wipes everything, so a restore reports a zero width
      glyph_table.push_back(fixed_row(glyph(1, 8'h60, 8, 8, 8, 8, 8, cgp_pkg::CLS_RESTORE),
                                      1, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      foreach (glyph_table[i])
         send_glyph(glyph_table[i].item, glyph_table[i].typed, glyph_table[i].typed_has,
                    glyph_table[i].typed_rsp);

      // random phases, each under its own gap setting; each write also drains the block
      write_gap(8'hFF);
      run_phase(180);
      write_gap(8'($urandom_range(1, 254)));
      run_phase(180);
      write_gap(8'h00);
      run_phase(180);
      write_gap(8'($urandom_range(1, 254)));
      // closing stretch runs at full rate on both sides
      quiet = 1'b1;
      run_phase(160);

      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
